// ===== sv/line_pixel_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_assert.svh
// Assertion macros for the line rasterizer; empty bodies in synthesis
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LPR_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// antecedent implies consequent in the next cycle
`define LPR_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`else

`define LPR_ASSERT_NOW(label, clock, resetn, ante, cons)
`define LPR_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

// ===== sv/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpr_pkg;

    // screen size registers
    localparam int SCREEN_BITS = 13;
    localparam int COLOR_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd240;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd320;

    // item modes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // direction and line status flags
    typedef struct packed {
        logic x_goes_down;
        logic y_goes_down;
        logic steep_line;
        logic line_active;
    } lpr_flags_t;

endpackage

// ===== sv/lpr_stepper.sv =====
// ----------------------------------------------------------------------------
// lpr_stepper
// Next line state and pixel result for one item, pure combinational
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpr_stepper #(
    parameter int COORD_BITS = 12
) (
    // item fields
    input  logic                               mode,
    input  logic [COORD_BITS-1:0]              start_x,
    input  logic [COORD_BITS-1:0]              start_y,
    input  logic [COORD_BITS-1:0]              end_x,
    input  logic [COORD_BITS-1:0]              end_y,
    input  logic [lpr_pkg::COLOR_BITS-1:0]     line_color,
    // screen size
    input  logic [lpr_pkg::SCREEN_BITS-1:0]    screen_width,
    input  logic [lpr_pkg::SCREEN_BITS-1:0]    screen_height,
    // current line state
    input  logic [COORD_BITS-1:0]              cur_x,
    input  logic [COORD_BITS-1:0]              cur_y,
    input  logic [COORD_BITS-1:0]              tgt_x,
    input  logic [COORD_BITS-1:0]              tgt_y,
    input  logic [COORD_BITS-1:0]              span_x,
    input  logic [COORD_BITS-1:0]              span_y,
    input  logic signed [COORD_BITS+1:0]       err,
    input  logic [lpr_pkg::COLOR_BITS-1:0]     color,
    input  lpr_pkg::lpr_flags_t                flags,
    // next line state
    output logic [COORD_BITS-1:0]              cur_x_next,
    output logic [COORD_BITS-1:0]              cur_y_next,
    output logic [COORD_BITS-1:0]              tgt_x_next,
    output logic [COORD_BITS-1:0]              tgt_y_next,
    output logic [COORD_BITS-1:0]              span_x_next,
    output logic [COORD_BITS-1:0]              span_y_next,
    output logic signed [COORD_BITS+1:0]       err_next,
    output logic [lpr_pkg::COLOR_BITS-1:0]     color_next,
    output lpr_pkg::lpr_flags_t                flags_next,
    // pixel result
    output logic                               res_valid,
    output logic [COORD_BITS-1:0]              res_x,
    output logic [COORD_BITS-1:0]              res_y,
    output logic [lpr_pkg::COLOR_BITS-1:0]     res_color,
    output logic                               res_on_screen,
    output logic                               res_last
);

    localparam int ERR_W = COORD_BITS + 2;
    localparam int CMP_W = (COORD_BITS > lpr_pkg::SCREEN_BITS) ? COORD_BITS
                                                                : lpr_pkg::SCREEN_BITS;

    logic                  sx_down;
    logic                  sy_down;
    logic [COORD_BITS-1:0] sx_span;
    logic [COORD_BITS-1:0] sy_span;
    logic                  s_steep;
    logic [ERR_W-1:0]      s_err;
    logic                  err_pos;
    logic [ERR_W-1:0]      two_dx;
    logic [ERR_W-1:0]      two_dy;
    logic [COORD_BITS-1:0] x_moved;
    logic [COORD_BITS-1:0] y_moved;
    logic                  last;

    // start item: directions, spans and initial error term
    always_comb
    begin
        sx_down = end_x < start_x;
        sy_down = end_y < start_y;
        sx_span = sx_down ? (start_x - end_x) : (end_x - start_x);
        sy_span = sy_down ? (start_y - end_y) : (end_y - start_y);
        s_steep = sy_span > sx_span;
        if (s_steep)
        begin
            s_err = ERR_W'({sx_span, 1'b0}) - ERR_W'(sy_span);
        end
        else
        begin
            s_err = ERR_W'({sy_span, 1'b0}) - ERR_W'(sx_span);
        end
    end

    // advance item: one step along the major axis
    assign err_pos = !err[ERR_W-1] && (err != '0);
    assign two_dx  = ERR_W'({span_x, 1'b0});
    assign two_dy  = ERR_W'({span_y, 1'b0});
    assign x_moved = flags.x_goes_down ? (cur_x - COORD_BITS'(1)) : (cur_x + COORD_BITS'(1));
    assign y_moved = flags.y_goes_down ? (cur_y - COORD_BITS'(1)) : (cur_y + COORD_BITS'(1));

    always_comb
    begin
        // hold state by default
        cur_x_next  = cur_x;
        cur_y_next  = cur_y;
        tgt_x_next  = tgt_x;
        tgt_y_next  = tgt_y;
        span_x_next = span_x;
        span_y_next = span_y;
        err_next    = err;
        color_next  = color;
        flags_next  = flags;
        last        = 1'b0;

        if (mode == lpr_pkg::MODE_START)
        begin
            cur_x_next  = start_x;
            cur_y_next  = start_y;
            tgt_x_next  = end_x;
            tgt_y_next  = end_y;
            span_x_next = sx_span;
            span_y_next = sy_span;
            err_next    = s_err;
            color_next  = line_color;
            last        = (start_x == end_x) && (start_y == end_y);
            flags_next.x_goes_down = sx_down;
            flags_next.y_goes_down = sy_down;
            flags_next.steep_line  = s_steep;
            flags_next.line_active = !last;
        end
        else if (flags.line_active)
        begin
            if (flags.steep_line)
            begin
                cur_y_next = y_moved;
                if (err_pos)
                begin
                    cur_x_next = x_moved;
                    err_next   = err + two_dx - two_dy;
                end
                else
                begin
                    err_next = err + two_dx;
                end
                last = (y_moved == tgt_y);
            end
            else
            begin
                cur_x_next = x_moved;
                if (err_pos)
                begin
                    cur_y_next = y_moved;
                    err_next   = err + two_dy - two_dx;
                end
                else
                begin
                    err_next = err + two_dy;
                end
                last = (x_moved == tgt_x);
            end
            flags_next.line_active = !last;
        end
    end

    // pixel result, all zero when advancing with no line
    always_comb
    begin
        res_valid = (mode == lpr_pkg::MODE_START) || flags.line_active;
        if (res_valid)
        begin
            res_x         = cur_x_next;
            res_y         = cur_y_next;
            res_color     = color_next;
            res_last      = last;
            res_on_screen = (CMP_W'(cur_x_next) < CMP_W'(screen_width))
                         && (CMP_W'(cur_y_next) < CMP_W'(screen_height));
        end
        else
        begin
            res_x         = '0;
            res_y         = '0;
            res_color     = '0;
            res_last      = 1'b0;
            res_on_screen = 1'b0;
        end
    end

endmodule

// ===== sv/line_pixel_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Bresenham line rasterizer with screen clipping flag, one pixel per item
// ----------------------------------------------------------------------------
// A start item (mode 0) loads both endpoints and the colour and returns the
// first pixel; each advance item (mode 1) returns the next pixel along the
// line, with last_pixel set on the second endpoint. Every item yields exactly
// one result; an advance with no line in progress gives pixel_valid = 0.
// Pixels beyond screen_width / screen_height are still returned, with
// on_screen = 0. Throughput is one item per clock: the line state registers
// feed a single add and compare on the error term, and the result lands in
// an output register in the cycle after the item is accepted. A new item is
// taken whenever the output register is empty or being drained. Write the
// screen size registers only while no item is in flight.
`timescale 1ns / 1ps

`include "line_pixel_rasterizer_assert.svh"

module line_pixel_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [lpr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lpr_pkg::SCREEN_BITS-1:0]       cfg_data,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [COORD_BITS-1:0]                 start_x,
    input  logic [COORD_BITS-1:0]                 start_y,
    input  logic [COORD_BITS-1:0]                 end_x,
    input  logic [COORD_BITS-1:0]                 end_y,
    input  logic [lpr_pkg::COLOR_BITS-1:0]        line_color,
    // pixel items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  pixel_valid,
    output logic [COORD_BITS-1:0]                 pixel_x,
    output logic [COORD_BITS-1:0]                 pixel_y,
    output logic [lpr_pkg::COLOR_BITS-1:0]        pixel_color,
    output logic                                  on_screen,
    output logic                                  last_pixel
);

    localparam int ERR_W = COORD_BITS + 2;

    logic [lpr_pkg::SCREEN_BITS-1:0] screen_width_reg;
    logic [lpr_pkg::SCREEN_BITS-1:0] screen_height_reg;

    logic [COORD_BITS-1:0]           cur_x_reg,  cur_x_next;
    logic [COORD_BITS-1:0]           cur_y_reg,  cur_y_next;
    logic [COORD_BITS-1:0]           tgt_x_reg,  tgt_x_next;
    logic [COORD_BITS-1:0]           tgt_y_reg,  tgt_y_next;
    logic [COORD_BITS-1:0]           span_x_reg, span_x_next;
    logic [COORD_BITS-1:0]           span_y_reg, span_y_next;
    logic signed [ERR_W-1:0]         err_reg,    err_next;
    logic [lpr_pkg::COLOR_BITS-1:0]  color_reg,  color_next;
    lpr_pkg::lpr_flags_t             flags_reg,  flags_next;

    logic                            out_valid_reg;
    logic                            pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0]           pix_x_reg,     pix_x_next;
    logic [COORD_BITS-1:0]           pix_y_reg,     pix_y_next;
    logic [lpr_pkg::COLOR_BITS-1:0]  pix_color_reg, pix_color_next;
    logic                            on_screen_reg, on_screen_next;
    logic                            last_reg,      last_next;

    logic                            in_fire;

    // handshake: take an item when the output register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= lpr_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg <= lpr_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lpr_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                lpr_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-item step logic
    lpr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .mode          (mode),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_color    (line_color),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .cur_x         (cur_x_reg),
        .cur_y         (cur_y_reg),
        .tgt_x         (tgt_x_reg),
        .tgt_y         (tgt_y_reg),
        .span_x        (span_x_reg),
        .span_y        (span_y_reg),
        .err           (err_reg),
        .color         (color_reg),
        .flags         (flags_reg),
        .cur_x_next    (cur_x_next),
        .cur_y_next    (cur_y_next),
        .tgt_x_next    (tgt_x_next),
        .tgt_y_next    (tgt_y_next),
        .span_x_next   (span_x_next),
        .span_y_next   (span_y_next),
        .err_next      (err_next),
        .color_next    (color_next),
        .flags_next    (flags_next),
        .res_valid     (pix_valid_next),
        .res_x         (pix_x_next),
        .res_y         (pix_y_next),
        .res_color     (pix_color_next),
        .res_on_screen (on_screen_next),
        .res_last      (last_next)
    );

    // line state, updated on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            span_x_reg <= '0;
            span_y_reg <= '0;
            err_reg    <= '0;
            color_reg  <= '0;
            flags_reg  <= '0;
        end
        else if (in_fire)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            span_x_reg <= span_x_next;
            span_y_reg <= span_y_next;
            err_reg    <= err_next;
            color_reg  <= color_next;
            flags_reg  <= flags_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_valid_reg <= pix_valid_next;
            pix_x_reg     <= pix_x_next;
            pix_y_reg     <= pix_y_next;
            pix_color_reg <= pix_color_next;
            on_screen_reg <= on_screen_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = pix_valid_reg;
    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign pixel_color = pix_color_reg;
    assign on_screen   = on_screen_reg;
    assign last_pixel  = last_reg;

    // checks
    `LPR_ASSERT_NOW(a_last_ends_line, clk, rst_n, out_valid_reg && pix_valid_reg && last_reg, !flags_reg.line_active)
    `LPR_ASSERT_NOW(a_mid_keeps_line, clk, rst_n, out_valid_reg && pix_valid_reg && !last_reg, flags_reg.line_active)
    `LPR_ASSERT_NOW(a_pixel_is_state, clk, rst_n, out_valid_reg && pix_valid_reg, (pix_x_reg == cur_x_reg) && (pix_y_reg == cur_y_reg))
    `LPR_ASSERT_NEXT(a_idle_advance, clk, rst_n, in_fire && (mode == lpr_pkg::MODE_ADVANCE) && !flags_reg.line_active, out_valid_reg && !pix_valid_reg)
    `LPR_ASSERT_NOW(a_stall_blocks, clk, rst_n, out_valid_reg && !out_ready, !in_ready)

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Bresenham line rasterizer
// ----------------------------------------------------------------------------
// Items are queued by the stimulus process and offered by a clocked driver.
// Each accepted item runs through a local line tracer that predicts the
// pixel it produces. A clocked monitor takes the pixels and compares them
// field by field with the predictions, in order. The run starts with
// hand-picked lines at the reset screen size. Random line traffic follows
// under several screen sizes, including one and zero rows or columns and the
// full 4096. One side or both stall in random bursts until the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_BITS  = 12;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int LONG_HOLD   = 80;
    localparam int COLOR_BITS  = lpr_pkg::COLOR_BITS;
    localparam int SCREEN_BITS = lpr_pkg::SCREEN_BITS;

    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0] color;
    } line_item_t;

    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  on_screen;
        logic                  last;
    } pixel_t;

    // block ports
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [lpr_pkg::CFG_INDEX_BITS-1:0] cfg_index = lpr_pkg::REG_SCREEN_WIDTH;
    logic [SCREEN_BITS-1:0]             cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               mode = lpr_pkg::MODE_START;
    logic [COORD_BITS-1:0]              start_x = '0;
    logic [COORD_BITS-1:0]              start_y = '0;
    logic [COORD_BITS-1:0]              end_x = '0;
    logic [COORD_BITS-1:0]              end_y = '0;
    logic [COLOR_BITS-1:0]              line_color = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic                               pixel_valid;
    logic [COORD_BITS-1:0]              pixel_x;
    logic [COORD_BITS-1:0]              pixel_y;
    logic [COLOR_BITS-1:0]              pixel_color;
    logic                               on_screen;
    logic                               last_pixel;

    // stimulus and scoreboard
    line_item_t items_to_send[$];
    pixel_t     pixels_due[$];
    line_item_t offered;
    int         queued_count = 0;
    int         mismatch_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         send_gap = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         long_hold_asked = 0;
    int         long_hold_done = 0;

    // tracer state, mirrors the block after reset
    logic [SCREEN_BITS-1:0] screen_w = lpr_pkg::SCREEN_WIDTH_RESET;
    logic [SCREEN_BITS-1:0] screen_h = lpr_pkg::SCREEN_HEIGHT_RESET;
    logic [COORD_BITS-1:0]  pen_x = '0;
    logic [COORD_BITS-1:0]  pen_y = '0;
    logic [COORD_BITS-1:0]  goal_x = '0;
    logic [COORD_BITS-1:0]  goal_y = '0;
    logic [COORD_BITS-1:0]  run_x = '0;
    logic [COORD_BITS-1:0]  run_y = '0;
    int                     bias = 0;
    logic                   x_back = 1'b0;
    logic                   y_back = 1'b0;
    logic                   y_major = 1'b0;
    logic                   drawing = 1'b0;
    logic [COLOR_BITS-1:0]  ink = '0;

    line_pixel_rasterizer #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_color  (line_color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .on_screen   (on_screen),
        .last_pixel  (last_pixel)
    );

    // traces one item through the line state and returns its pixel
    function automatic pixel_t rasterize_item(input line_item_t it);
        pixel_t px;
        logic   done;
        px = '0;
        if (it.mode == lpr_pkg::MODE_START)
        begin
            pen_x   = it.sx;
            pen_y   = it.sy;
            goal_x  = it.ex;
            goal_y  = it.ey;
            ink     = it.color;
            x_back  = it.ex < it.sx;
            y_back  = it.ey < it.sy;
            run_x   = x_back ? it.sx - it.ex : it.ex - it.sx;
            run_y   = y_back ? it.sy - it.ey : it.ey - it.sy;
            y_major = run_y > run_x;
            bias    = y_major ? 2 * int'(run_x) - int'(run_y)
                              : 2 * int'(run_y) - int'(run_x);
            done    = (it.sx == it.ex) && (it.sy == it.ey);
            drawing = !done;
        end
        else
        begin
            // advance with no line in progress: empty pixel
            if (!drawing)
                return px;
            if (y_major)
            begin
                pen_y = y_back ? pen_y - 1'b1 : pen_y + 1'b1;
                if (bias > 0)
                begin
                    pen_x = x_back ? pen_x - 1'b1 : pen_x + 1'b1;
                    bias += 2 * int'(run_x) - 2 * int'(run_y);
                end
                else
                begin
                    bias += 2 * int'(run_x);
                end
                done = (pen_y == goal_y);
            end
            else
            begin
                pen_x = x_back ? pen_x - 1'b1 : pen_x + 1'b1;
                if (bias > 0)
                begin
                    pen_y = y_back ? pen_y - 1'b1 : pen_y + 1'b1;
                    bias += 2 * int'(run_y) - 2 * int'(run_x);
                end
                else
                begin
                    bias += 2 * int'(run_y);
                end
                done = (pen_x == goal_x);
            end
            if (done)
                drawing = 1'b0;
        end
        px.valid     = 1'b1;
        px.x         = pen_x;
        px.y         = pen_y;
        px.color     = ink;
        px.on_screen = (pen_x < screen_w) && (pen_y < screen_h);
        px.last      = done;
        return px;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // mostly near the origin so pixels land on screen, sometimes anywhere or near the far edge
    function automatic int pick_coord();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return COORD_MAX - int'($urandom_range(0, 20));
        if (roll < 3)
            return int'($urandom_range(0, COORD_MAX));
        return int'($urandom_range(0, 400));
    endfunction

    task automatic queue_advances(input int count);
        line_item_t it;
        for (int i = 0; i < count; i++)
        begin
            // fields other than mode are ignored, fill them with noise
            it.mode  = lpr_pkg::MODE_ADVANCE;
            it.sx    = COORD_BITS'($urandom);
            it.sy    = COORD_BITS'($urandom);
            it.ex    = COORD_BITS'($urandom);
            it.ey    = COORD_BITS'($urandom);
            it.color = COLOR_BITS'($urandom);
            items_to_send.push_back(it);
            queued_count++;
        end
    endtask

    task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                              input int color, input int advances);
        line_item_t it;
        it.mode  = lpr_pkg::MODE_START;
        it.sx    = COORD_BITS'(sx);
        it.sy    = COORD_BITS'(sy);
        it.ex    = COORD_BITS'(ex);
        it.ey    = COORD_BITS'(ey);
        it.color = COLOR_BITS'(color);
        items_to_send.push_back(it);
        queued_count++;
        queue_advances(advances);
    endtask

    task automatic queue_random_line();
        int sx, sy, ex, ey, dx, dy, reach, major, steps, roll;
        roll  = $urandom_range(0, 19);
        reach = (roll == 0) ? 300 : (roll < 5) ? 60 : 12;
        sx    = pick_coord();
        sy    = pick_coord();
        ex    = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
        ey    = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
        dx    = (ex > sx) ? ex - sx : sx - ex;
        dy    = (ey > sy) ? ey - sy : sy - ey;
        major = (dy > dx) ? dy : dx;
        // mostly whole lines, some cut short, some stepped past the end
        roll = $urandom_range(0, 9);
        if (roll < 7)
            steps = major;
        else if (roll < 9)
            steps = $urandom_range(0, major);
        else
            steps = major + $urandom_range(1, 3);
        queue_line(sx, sy, ex, ey, $urandom_range(0, 16'hFFFF), steps);
    endtask

    task automatic fill_random(input int budget);
        int goal;
        int kind;
        goal = queued_count + budget;
        while (queued_count < goal)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                queue_advances($urandom_range(1, 3));
            else if (kind == 1)
                queue_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                           $urandom_range(0, 16'hFFFF), $urandom_range(0, 6));
            else
                queue_random_line();
        end
    endtask

    // wait until every queued item went in and every pixel came out
    task automatic wait_drained();
        do
            @(posedge clk);
        while (items_to_send.size() != 0 || in_valid || pixels_due.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_screen(input logic [SCREEN_BITS-1:0] w,
                              input logic [SCREEN_BITS-1:0] h);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lpr_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= lpr_pkg::REG_SCREEN_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        screen_w = w;
        screen_h = h;
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // driver: offers queued items, predicts the pixel of each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pixels_due.push_back(rasterize_item(offered));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (items_to_send.size() > 0)
                begin
                    offered = items_to_send.pop_front();
                    mode       <= offered.mode;
                    start_x    <= offered.sx;
                    start_y    <= offered.sy;
                    end_x      <= offered.ex;
                    end_y      <= offered.ey;
                    line_color <= offered.color;
                    in_valid   <= 1'b1;
                    if ($urandom_range(0, 99) < send_idle_pct)
                        send_gap = $urandom_range(1, 13);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: takes pixels and checks them against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    $display("%0t: pixel with none expected, got x %0d y %0d", $time,
                             pixel_x, pixel_y);
                    mismatch_count++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("pixel_valid", 32'(want.valid), 32'(pixel_valid));
                    check_field("pixel_x", 32'(want.x), 32'(pixel_x));
                    check_field("pixel_y", 32'(want.y), 32'(pixel_y));
                    check_field("pixel_color", 32'(want.color), 32'(pixel_color));
                    check_field("on_screen", 32'(want.on_screen), 32'(on_screen));
                    check_field("last_pixel", 32'(want.last), 32'(last_pixel));
                end
            end
            // long hold-off on request, else random stall bursts
            if (long_hold_done != long_hold_asked)
            begin
                long_hold_done = long_hold_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // hand-picked lines at the reset screen size
        send_idle_pct = 20;
        recv_idle_pct = 20;
        queue_advances(1);                                // advance before any line
        queue_line(0, 0, 0, 0, 16'h0000, 1);              // single point, then nothing left
        queue_line(4095, 4095, 4095, 4095, 16'hFFFF, 0);  // single point off screen
        queue_line(10, 5, 13, 5, 16'h1234, 3);            // horizontal
        queue_line(3, 8, 3, 6, 16'hABCD, 2);              // vertical, y decreasing
        queue_line(0, 0, 2, 2, 16'h5555, 2);              // diagonal, x is major
        queue_line(4095, 0, 0, 4095, 16'hAAAA, 2);        // dropped by the next start
        queue_line(238, 318, 240, 322, 16'h00FF, 4);      // steep, across both screen edges

        // full screen, receiver stops for a long stretch while items keep coming
        set_screen(13'd4096, 13'd4096);
        send_idle_pct = 30;
        recv_idle_pct = 10;
        fill_random(320);
        long_hold_asked++;

        // one by one pixel
        set_screen(13'd1, 13'd1);
        send_idle_pct = 0;
        recv_idle_pct = 30;
        fill_random(320);

        // zero width clips everything
        set_screen(13'd0, 13'd320);
        send_idle_pct = 10;
        recv_idle_pct = 0;
        fill_random(320);

        // random size, sender waits for the pipe to run dry halfway through
        set_screen(SCREEN_BITS'($urandom_range(1, 4096)),
                   SCREEN_BITS'($urandom_range(1, 4096)));
        send_idle_pct = 25;
        recv_idle_pct = 25;
        fill_random(160);
        wait_drained();
        fill_random(160);

        // zero height
        set_screen(13'd240, 13'd0);
        send_idle_pct = 15;
        recv_idle_pct = 15;
        fill_random(300);

        // last stretch at full rate
        set_screen(SCREEN_BITS'($urandom_range(1, 4096)),
                   SCREEN_BITS'($urandom_range(1, 4096)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(300);

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
